@@ hw/rtl/sida_pkg.sv @@
// ----------------------------------------------------------------------------
// sida_pkg
// Shared widths and character codes for the signed decimal text unit.
// ----------------------------------------------------------------------------
package sida_pkg;

	localparam int VALUE_W   = 32;
	localparam int CHAR_W    = 8;
	localparam int DIGIT_W   = 4;
	localparam int STEP_BITS = 8;
	localparam int DABBLE_STAGES = VALUE_W / STEP_BITS;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

	localparam logic [DIGIT_W-1:0] DABBLE_LIMIT  = 4'd5;
	localparam logic [DIGIT_W-1:0] DABBLE_ADJUST = 4'd3;

endpackage

@@ hw/rtl/sida_dabble_stage.sv @@
// ----------------------------------------------------------------------------
// sida_dabble_stage
// One registered stage of the binary to bcd shift-and-add-3 conversion.
// ----------------------------------------------------------------------------
module sida_dabble_stage import sida_pkg::*; #(
	parameter int NDIG = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    in_neg,
	input  logic [DIGIT_W*NDIG-1:0] in_bcd,
	input  logic [VALUE_W-1:0]      in_bin,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    out_neg,
	output logic [DIGIT_W*NDIG-1:0] out_bcd,
	output logic [VALUE_W-1:0]      out_bin
);

	localparam int BCD_W = DIGIT_W * NDIG;

	logic              valid_sn;
	logic              neg_sn;
	logic [BCD_W-1:0]  bcd_sn;
	logic [VALUE_W-1:0] bin_sn;
	logic [BCD_W-1:0]  bcd_c;
	logic [VALUE_W-1:0] bin_c;

	assign in_stall = valid_sn && out_stall;

	always_comb begin
		bcd_c = in_bcd;
		bin_c = in_bin;
		for (int s = 0; s < STEP_BITS; s++) begin
			for (int d = 0; d < NDIG; d++) begin
				if (bcd_c[DIGIT_W*d +: DIGIT_W] >= DABBLE_LIMIT) begin
					bcd_c[DIGIT_W*d +: DIGIT_W] = bcd_c[DIGIT_W*d +: DIGIT_W] + DABBLE_ADJUST;
				end
			end
			bcd_c = {bcd_c[BCD_W-2:0], bin_c[VALUE_W-1]};
			bin_c = {bin_c[VALUE_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (!in_stall) begin
			valid_sn <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			neg_sn <= in_neg;
			bcd_sn <= bcd_c;
			bin_sn <= bin_c;
		end
	end

	assign out_valid = valid_sn;
	assign out_neg   = neg_sn;
	assign out_bcd   = bcd_sn;
	assign out_bin   = bin_sn;

endmodule

@@ hw/rtl/sida_serializer.sv @@
// ----------------------------------------------------------------------------
// sida_serializer
// Holds one converted value and sends its text one character per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module sida_serializer import sida_pkg::*; #(
	parameter int NDIG = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    in_neg,
	input  logic [DIGIT_W*NDIG-1:0] in_bcd,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [CHAR_W-1:0]       out_char,
	output logic                    out_last
);

	localparam int BCD_W = DIGIT_W * NDIG;
	localparam int IDX_W = $clog2(NDIG);

	logic               busy_q;
	logic               sign_q;
	logic [IDX_W-1:0]   idx_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [IDX_W-1:0]   top_c;
	logic               finish;
	logic               load;
	logic [DIGIT_W-1:0] digit;

	// highest nonzero digit, zero itself prints one digit
	always_comb begin
		top_c = '0;
		for (int d = 0; d < NDIG; d++) begin
			if (in_bcd[DIGIT_W*d +: DIGIT_W] != '0) begin
				top_c = IDX_W'(d);
			end
		end
	end

	assign finish   = !sign_q && (idx_q == '0);
	assign in_stall = busy_q && !(finish && !out_stall);
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sign_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			sign_q <= in_neg;
			idx_q  <= top_c;
		end else if (busy_q && !out_stall) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else if (idx_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bcd_q <= in_bcd;
		end
	end

	assign digit     = bcd_q[DIGIT_W*idx_q +: DIGIT_W];
	assign out_valid = busy_q;
	assign out_char  = sign_q ? CHAR_MINUS : (CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit});
	assign out_last  = finish;

endmodule

@@ hw/rtl/signed_int_to_decimal_ascii_unit.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Prints a signed 32-bit value as decimal ascii text, one character per item.
// ----------------------------------------------------------------------------
//  channel | valid       | stall       | payload
//  value   | value_valid | value_stall | value[31:0] signed
//  char    | char_valid  | char_stall  | ascii_char[7:0], last_char
//
//  a value reaches its first character through one sign/magnitude stage,
//  four bcd stages of eight shifts each, and one load into the serializer
//  a value then gives 1 to 11 characters, one per cycle while char_stall is low;
//  the next value loads as the last character leaves, so text runs back to back
//  stall on the char channel holds the serializer and backs up every stage
//  reset clears only the valid and sequencing flags
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit import sida_pkg::*; #(
	parameter int MAX_DIGITS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               value_valid,
	output logic               value_stall,
	input  logic signed [VALUE_W-1:0] value,
	output logic               char_valid,
	input  logic               char_stall,
	output logic [CHAR_W-1:0]  ascii_char,
	output logic               last_char
);

	localparam int BCD_W = DIGIT_W * MAX_DIGITS;

	logic               valid_s1;
	logic               neg_s1;
	logic [VALUE_W-1:0] mag_s1;

	logic               st_valid [DABBLE_STAGES+1];
	logic               st_stall [DABBLE_STAGES+1];
	logic               st_neg   [DABBLE_STAGES+1];
	logic [BCD_W-1:0]   st_bcd   [DABBLE_STAGES+1];
	logic [VALUE_W-1:0] st_bin   [DABBLE_STAGES+1];

	assign value_stall = valid_s1 && st_stall[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!value_stall) begin
			valid_s1 <= value_valid;
		end
	end

	// the most negative value gives 0x80000000, exact as unsigned
	always_ff @(posedge clk) begin
		if (!value_stall && value_valid) begin
			neg_s1 <= value[VALUE_W-1];
			mag_s1 <= value[VALUE_W-1] ? (~value + 1'b1) : value;
		end
	end

	assign st_valid[0] = valid_s1;
	assign st_neg[0]   = neg_s1;
	assign st_bcd[0]   = '0;
	assign st_bin[0]   = mag_s1;

	for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
		sida_dabble_stage #(
			.NDIG (MAX_DIGITS)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (st_valid[g]),
			.in_stall  (st_stall[g]),
			.in_neg    (st_neg[g]),
			.in_bcd    (st_bcd[g]),
			.in_bin    (st_bin[g]),
			.out_valid (st_valid[g+1]),
			.out_stall (st_stall[g+1]),
			.out_neg   (st_neg[g+1]),
			.out_bcd   (st_bcd[g+1]),
			.out_bin   (st_bin[g+1])
		);
	end

	sida_serializer #(
		.NDIG (MAX_DIGITS)
	) u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (st_valid[DABBLE_STAGES]),
		.in_stall  (st_stall[DABBLE_STAGES]),
		.in_neg    (st_neg[DABBLE_STAGES]),
		.in_bcd    (st_bcd[DABBLE_STAGES]),
		.out_valid (char_valid),
		.out_stall (char_stall),
		.out_char  (ascii_char),
		.out_last  (last_char)
	);

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && (ascii_char == CHAR_MINUS) |-> !last_char)
		else $error("minus sign flagged as last character");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && (ascii_char != CHAR_MINUS) |->
		(ascii_char >= CHAR_ZERO) && (ascii_char <= CHAR_ZERO + 8'd9))
		else $error("character is neither sign nor digit");

	a_run_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_stall && !last_char |=> char_valid)
		else $error("gap inside a character run");

endmodule
